// File: hdl/dsf_pkg.sv
package dsf_pkg;

	// Width of every position, velocity and force component (signed Q16.16).
	localparam int DSF_DATA_W = 32;
	// Width of the multiplier digit taken in one pipeline stage.
	localparam int DSF_DIGIT_W = 16;
	// Width of the unsigned configuration registers.
	localparam int DSF_CFG_W = 31;
	// Width of the configuration write data and of force_scale.
	localparam int DSF_CFG_DATA_W = 32;
	localparam int DSF_CFG_IDX_W = 3;

	localparam logic [DSF_CFG_IDX_W-1:0] REG_REST_LENGTH = 3'd0;
	localparam logic [DSF_CFG_IDX_W-1:0] REG_STIFFNESS = 3'd1;
	localparam logic [DSF_CFG_IDX_W-1:0] REG_DAMPING = 3'd2;
	localparam logic [DSF_CFG_IDX_W-1:0] REG_FORCE_SCALE = 3'd3;
	localparam logic [DSF_CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd4;

	localparam logic [DSF_CFG_DATA_W-1:0] DSF_FORCE_SCALE_RST = 32'd65536;
	localparam logic [DSF_CFG_W-1:0] DSF_MIN_LENGTH_RST = 31'd1;

	typedef struct packed {
		logic signed [DSF_DATA_W-1:0] pos_a_x;
		logic signed [DSF_DATA_W-1:0] pos_a_y;
		logic signed [DSF_DATA_W-1:0] pos_a_z;
		logic signed [DSF_DATA_W-1:0] pos_b_x;
		logic signed [DSF_DATA_W-1:0] pos_b_y;
		logic signed [DSF_DATA_W-1:0] pos_b_z;
		logic signed [DSF_DATA_W-1:0] vel_a_x;
		logic signed [DSF_DATA_W-1:0] vel_a_y;
		logic signed [DSF_DATA_W-1:0] vel_a_z;
		logic signed [DSF_DATA_W-1:0] vel_b_x;
		logic signed [DSF_DATA_W-1:0] vel_b_y;
		logic signed [DSF_DATA_W-1:0] vel_b_z;
	} dsf_req_t;

	typedef struct packed {
		logic signed [DSF_DATA_W-1:0] force_x;
		logic signed [DSF_DATA_W-1:0] force_y;
		logic signed [DSF_DATA_W-1:0] force_z;
		logic degenerate;
		logic saturated;
	} dsf_res_t;

endpackage

// File: hdl/dsf_delay.sv
module dsf_delay import dsf_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_s [DEPTH];

	always_ff @(posedge clk) begin
		line_s[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			line_s[k] <= line_s[k-1];
		end
	end

	assign dout = line_s[DEPTH-1];

endmodule

// File: hdl/dsf_mul.sv
module dsf_mul import dsf_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	// One digit of b is multiplied in per stage and added into the running sum.
	localparam int DIG = DSF_DIGIT_W;
	localparam int N = (BW + DIG - 1) / DIG;
	localparam int BPW = N * DIG;
	localparam int PW = AW + BPW;

	logic [AW-1:0]  a_s   [N];
	logic [BPW-1:0] b_s   [N];
	logic [PW-1:0]  acc_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [AW-1:0]     a_in;
		logic [BPW-1:0]    b_in;
		logic [PW-1:0]     acc_in;
		logic [AW+DIG-1:0] pp;

		if (k == 0) begin : g_first
			assign a_in = a;
			assign b_in = BPW'(b);
			assign acc_in = '0;
		end else begin : g_next
			assign a_in = a_s[k-1];
			assign b_in = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		assign pp = a_in * b_in[k*DIG +: DIG];

		always_ff @(posedge clk) begin
			a_s[k] <= a_in;
			b_s[k] <= b_in;
			acc_s[k] <= acc_in + (PW'(pp) << (k * DIG));
		end
	end

	assign p = acc_s[N-1][AW+BW-1:0];

endmodule

// File: hdl/dsf_sqrt.sv
module dsf_sqrt import dsf_pkg::*; #(
	parameter int RW = 33
) (
	input  logic            clk,
	input  logic [2*RW-1:0] s,
	output logic [RW-1:0]   root
);

	// Digit-by-digit square root, one root bit per stage, from the top bit down.
	localparam int SW = 2 * RW;

	logic [SW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic [SW-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [SW-1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = s;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
		assign trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
		assign ge = rem_in >= trial;

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? rem_in - trial : rem_in;
			root_s[k] <= ge ? (root_in | (RW'(1) << B)) : root_in;
		end
	end

	assign root = root_s[RW-1];

endmodule

// File: hdl/dsf_div.sv
module dsf_div import dsf_pkg::*; #(
	parameter int NW = 66,
	parameter int DW = 33,
	parameter int QW = 33
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	// Restoring division, one quotient bit per stage. The quotient is known to
	// fit in QW bits, so the bits of num above them start out as the remainder.

	logic [QW-1:0] lo_s  [QW];
	logic [DW-1:0] den_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [QW-1:0] lo_in;
		logic [DW-1:0] den_in;
		logic [DW-1:0] rem_in;
		logic [QW-1:0] q_in;
		logic [DW:0]   sh;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign lo_in = num[QW-1:0];
			assign den_in = den;
			assign rem_in = DW'(num[NW-1:QW]);
			assign q_in = '0;
		end else begin : g_next
			assign lo_in = lo_s[k-1];
			assign den_in = den_s[k-1];
			assign rem_in = rem_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign sh = {rem_in, lo_in[QW-1-k]};
		assign ge = sh >= {1'b0, den_in};
		assign diff = sh - {1'b0, den_in};

		always_ff @(posedge clk) begin
			lo_s[k] <= lo_in;
			den_s[k] <= den_in;
			rem_s[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
			q_s[k] <= {q_in[QW-2:0], ge};
		end
	end

	assign quo = q_s[QW-1];

endmodule

// File: hdl/damped_spring_force.sv
// Damped linear spring force between two 3D nodes, signed Q16.16 throughout.
//
// Usage: drive a request (positions and velocities of both end nodes) and raise
// start. A request is taken at every rising edge with start high and busy low;
// busy never rises, so one spring may be issued in every clock cycle.
// Each result appears on result for exactly one cycle, marked by done, in request
// order. The receiver cannot hold results off, and the pipeline never needs it to:
// it has no stall path. A request passes through the length square root
// (DATA_W+1 stages), the velocity divider (DATA_W+2 stages), the 64-stage force
// dividers and the digit-pipelined multipliers. Throughput is one spring per cycle.
// Configuration is written through cfg_we/cfg_index/cfg_data while no request
// is in flight; an index beyond the register list is ignored.
// Reset clears all in-flight requests and loads the register defaults:
// zero rest length, stiffness and damping, unit force scale, min length 1 LSB.
module damped_spring_force import dsf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  dsf_req_t                  request,
	output logic                      done,
	output dsf_res_t                  result,
	input  logic                      cfg_we,
	input  logic [DSF_CFG_IDX_W-1:0]  cfg_index,
	input  logic [DSF_CFG_DATA_W-1:0] cfg_data
);

	localparam int W = DSF_DATA_W;
	localparam int DIG = DSF_DIGIT_W;
	localparam int CW = DSF_CFG_W;
	localparam int FSW = DSF_CFG_DATA_W;
	localparam int RW = W + 1;                       // length width
	localparam int SQW = 2 * RW;                     // squared length width
	// Velocity magnitude width: a very short spring can see up to three times
	// the largest velocity component along its direction.
	localparam int QV = W + 2;
	localparam int EMW = (W + 1 > CW) ? W + 1 : CW;  // stretch magnitude width
	localparam int TW = ((EMW > QV) ? EMW : QV) + CW + 1; // spring term magnitude width
	localparam int GW = 63;                          // scaled term magnitude width
	localparam int FNW = GW + W;                     // force numerator width
	localparam int QF = 64;                          // force quotient width

	localparam int ML1 = (W + DIG - 1) / DIG;
	localparam int ML2 = (CW + DIG - 1) / DIG;
	localparam int ML3 = (FSW + DIG - 1) / DIG;

	// Cycle at which each named value is held in its register.
	localparam int T1 = 1;
	localparam int T2 = T1 + ML1 + 1;
	localparam int T3 = T2 + 1;
	localparam int TL = T2 + RW;
	localparam int TE = TL + 1;
	localparam int TV = TL + QV;
	localparam int TM2 = TV + ML2;
	localparam int TT = TM2 + 1;
	localparam int TM3 = TT + ML3;
	localparam int TG = TM3 + 1;
	localparam int TM4 = TG + ML1;
	localparam int TF = TM4 + QF;
	localparam int TO = TF + 1;

	localparam logic [TW-1:0] GMAX = TW'(64'h7FFF_FFFF_FFFF_FFFF);
	localparam logic [QF-1:0] FPMAX = QF'((64'd1 << (W - 1)) - 64'd1);
	localparam logic [QF-1:0] FNMAX = QF'(64'd1 << (W - 1));

	// The pipeline never stalls, so a request is always taken.
	assign busy = 1'b0;

	// ---------------------------------------------------------------- config
	logic [CW-1:0]  rest_q, stiff_q, damp_q, min_q;
	logic [FSW-1:0] fsmag_q;
	logic           fsneg_q;

	// force_scale is kept as sign and magnitude, which is what the datapath uses.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= '0;
			stiff_q <= '0;
			damp_q <= '0;
			fsmag_q <= DSF_FORCE_SCALE_RST;
			fsneg_q <= 1'b0;
			min_q <= DSF_MIN_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REST_LENGTH: rest_q <= cfg_data[CW-1:0];
				REG_STIFFNESS:   stiff_q <= cfg_data[CW-1:0];
				REG_DAMPING:     damp_q <= cfg_data[CW-1:0];
				REG_FORCE_SCALE: begin
					fsneg_q <= cfg_data[FSW-1];
					fsmag_q <= cfg_data[FSW-1] ? ~cfg_data + 1'b1 : cfg_data;
				end
				REG_MIN_LENGTH:  min_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- valid line
	logic [TO-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TO-2:0], start};
		end
	end

	assign done = vld_q[TO-1];

	// ---------------------------------------------------------------- stage 1
	// Difference vectors as sign and magnitude. A difference of two W-bit
	// values has a magnitude below 2^W.
	function automatic logic [W:0] sdiff(input logic [W-1:0] hi, input logic [W-1:0] lo);
		logic [W:0] d;
		d = {hi[W-1], hi} - {lo[W-1], lo};
		return d;
	endfunction

	logic [2:0][W-1:0] pa, pb, va, vb;
	logic [2:0][W-1:0] dmag, vmag;
	logic [2:0]        dneg, vneg;

	assign pa = {request.pos_a_z, request.pos_a_y, request.pos_a_x};
	assign pb = {request.pos_b_z, request.pos_b_y, request.pos_b_x};
	assign va = {request.vel_a_z, request.vel_a_y, request.vel_a_x};
	assign vb = {request.vel_b_z, request.vel_b_y, request.vel_b_x};

	always_comb begin
		logic [W:0] dd, dv, nd, nv;
		for (int i = 0; i < 3; i++) begin
			dd = sdiff(pb[i], pa[i]);
			dv = sdiff(vb[i], va[i]);
			nd = ~dd + 1'b1;
			nv = ~dv + 1'b1;
			dneg[i] = dd[W];
			vneg[i] = dv[W];
			dmag[i] = dd[W] ? nd[W-1:0] : dd[W-1:0];
			vmag[i] = dv[W] ? nv[W-1:0] : dv[W-1:0];
		end
	end

	logic [2:0][W-1:0] dmag_s1, vmag_s1;
	logic [2:0]        dneg_s1, vneg_s1;

	always_ff @(posedge clk) begin
		dmag_s1 <= dmag;
		vmag_s1 <= vmag;
		dneg_s1 <= dneg;
		vneg_s1 <= vneg;
	end

	// ---------------------------------------------------------------- squares, dot terms
	logic [2:0][2*W-1:0] sqp, dotp;
	logic [2:0]          pneg_d;

	for (genvar i = 0; i < 3; i++) begin : g_m1
		dsf_mul #(.AW(W), .BW(W)) u_sq (
			.clk(clk), .a(dmag_s1[i]), .b(dmag_s1[i]), .p(sqp[i])
		);
		dsf_mul #(.AW(W), .BW(W)) u_dot (
			.clk(clk), .a(vmag_s1[i]), .b(dmag_s1[i]), .p(dotp[i])
		);
	end

	dsf_delay #(.WIDTH(3), .DEPTH(ML1)) u_pneg_dly (
		.clk(clk), .din(dneg_s1 ^ vneg_s1), .dout(pneg_d)
	);

	// ---------------------------------------------------------------- stage 2
	// The dot product is summed as a positive and a negative part so that its
	// magnitude comes out of one subtract in the next stage.
	logic [SQW-1:0] sq_s2, dpos_s2, dneg_s2;

	always_ff @(posedge clk) begin
		logic [SQW-1:0] sp, sn;
		sp = '0;
		sn = '0;
		for (int i = 0; i < 3; i++) begin
			if (pneg_d[i]) begin
				sn = sn + SQW'(dotp[i]);
			end else begin
				sp = sp + SQW'(dotp[i]);
			end
		end
		sq_s2 <= SQW'(sqp[0]) + SQW'(sqp[1]) + SQW'(sqp[2]);
		dpos_s2 <= sp;
		dneg_s2 <= sn;
	end

	// ---------------------------------------------------------------- stage 3
	logic [SQW-1:0] dotmag_s3;
	logic           dotneg_s3;

	always_ff @(posedge clk) begin
		dotneg_s3 <= dneg_s2 > dpos_s2;
		dotmag_s3 <= (dneg_s2 > dpos_s2) ? dneg_s2 - dpos_s2 : dpos_s2 - dneg_s2;
	end

	// ---------------------------------------------------------------- length
	logic [RW-1:0] len;

	dsf_sqrt #(.RW(RW)) u_sqrt (
		.clk(clk), .s(sq_s2), .root(len)
	);

	// ---------------------------------------------------------------- velocity along spring
	logic [SQW-1:0] dotmag_d;
	logic [QV-1:0]  velmag;
	logic           velneg_d;

	dsf_delay #(.WIDTH(SQW), .DEPTH(TL - T3)) u_dot_dly (
		.clk(clk), .din(dotmag_s3), .dout(dotmag_d)
	);

	dsf_delay #(.WIDTH(1), .DEPTH(TM2 - T3)) u_dotneg_dly (
		.clk(clk), .din(dotneg_s3), .dout(velneg_d)
	);

	dsf_div #(.NW(SQW), .DW(RW), .QW(QV)) u_vdiv (
		.clk(clk), .num(dotmag_d), .den(len), .quo(velmag)
	);

	// ---------------------------------------------------------------- stage 4
	// Stretch against the rest length, and the degenerate test.
	logic [EMW-1:0] emag_s4;
	logic           eneg_s4, deg_s4;

	always_ff @(posedge clk) begin
		logic [EMW-1:0] lx, rx;
		lx = EMW'(len);
		rx = EMW'(rest_q);
		eneg_s4 <= lx < rx;
		emag_s4 <= (lx < rx) ? rx - lx : lx - rx;
		deg_s4 <= (len == '0) || (lx < EMW'(min_q));
	end

	logic [EMW-1:0] emag_d;
	logic           eneg_d;

	dsf_delay #(.WIDTH(EMW), .DEPTH(TV - TE)) u_emag_dly (
		.clk(clk), .din(emag_s4), .dout(emag_d)
	);

	dsf_delay #(.WIDTH(1), .DEPTH(TM2 - TE)) u_eneg_dly (
		.clk(clk), .din(eneg_s4), .dout(eneg_d)
	);

	// ---------------------------------------------------------------- spring and damper terms
	logic [EMW+CW-1:0] pk;
	logic [QV+CW-1:0]  pd;

	dsf_mul #(.AW(EMW), .BW(CW)) u_kmul (
		.clk(clk), .a(emag_d), .b(stiff_q), .p(pk)
	);

	dsf_mul #(.AW(QV), .BW(CW)) u_dmul (
		.clk(clk), .a(velmag), .b(damp_q), .p(pd)
	);

	// ---------------------------------------------------------------- stage 5
	logic [TW-1:0] tmag_s5;
	logic          tneg_s5;

	always_ff @(posedge clk) begin
		logic [TW-1:0] tk, td;
		tk = TW'(pk);
		td = TW'(pd);
		if (eneg_d == velneg_d) begin
			tmag_s5 <= tk + td;
			tneg_s5 <= eneg_d;
		end else if (tk >= td) begin
			tmag_s5 <= tk - td;
			tneg_s5 <= eneg_d;
		end else begin
			tmag_s5 <= td - tk;
			tneg_s5 <= velneg_d;
		end
	end

	// ---------------------------------------------------------------- force scale
	logic [TW+FSW-1:0] pg;
	logic              tneg_d;

	dsf_mul #(.AW(TW), .BW(FSW)) u_smul (
		.clk(clk), .a(tmag_s5), .b(fsmag_q), .p(pg)
	);

	dsf_delay #(.WIDTH(1), .DEPTH(ML3)) u_tneg_dly (
		.clk(clk), .din(tneg_s5), .dout(tneg_d)
	);

	// ---------------------------------------------------------------- stage 6
	// Drop the 32 fraction bits of the product and clamp the magnitude to 63 bits.
	logic [GW-1:0] gmag_s6;
	logic          gneg_s6, gsat_s6;

	always_ff @(posedge clk) begin
		logic [TW-1:0] graw;
		graw = pg[TW+FSW-1:FSW];
		gsat_s6 <= graw > GMAX;
		gmag_s6 <= (graw > GMAX) ? GMAX[GW-1:0] : graw[GW-1:0];
		gneg_s6 <= tneg_d ^ fsneg_q;
	end

	// ---------------------------------------------------------------- force components
	logic [2:0][W:0]   dsm_d;
	logic [2:0][FNW-1:0] pf;
	logic [2:0]        fneg;
	logic [3:0]        fflag_d;
	logic [RW-1:0]     len_d;
	logic              deg_d;
	logic [2:0][QF-1:0] fq;

	dsf_delay #(.WIDTH(3 * (W + 1)), .DEPTH(TG - T1)) u_d_dly (
		.clk(clk),
		.din({dneg_s1[2], dmag_s1[2], dneg_s1[1], dmag_s1[1], dneg_s1[0], dmag_s1[0]}),
		.dout(dsm_d)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fneg[i] = gneg_s6 ^ dsm_d[i][W];
		end
	end

	dsf_delay #(.WIDTH(4), .DEPTH(TF - TG)) u_flag_dly (
		.clk(clk), .din({gsat_s6, fneg}), .dout(fflag_d)
	);

	dsf_delay #(.WIDTH(RW), .DEPTH(TM4 - TL)) u_len_dly (
		.clk(clk), .din(len), .dout(len_d)
	);

	dsf_delay #(.WIDTH(1), .DEPTH(TF - TE)) u_deg_dly (
		.clk(clk), .din(deg_s4), .dout(deg_d)
	);

	for (genvar i = 0; i < 3; i++) begin : g_force
		dsf_mul #(.AW(GW), .BW(W)) u_fmul (
			.clk(clk), .a(gmag_s6), .b(dsm_d[i][W-1:0]), .p(pf[i])
		);
		dsf_div #(.NW(FNW), .DW(RW), .QW(QF)) u_fdiv (
			.clk(clk), .num(pf[i]), .den(len_d), .quo(fq[i])
		);
	end

	// ---------------------------------------------------------------- output register
	// Each component is clamped to the signed W-bit range, and a degenerate
	// spring overrides everything with a zero force.
	logic [2:0][W-1:0] fout;
	logic [2:0]        fsat;

	always_comb begin
		logic [W-1:0] cm;
		for (int i = 0; i < 3; i++) begin
			if (fflag_d[i]) begin
				fsat[i] = fq[i] > FNMAX;
				cm = fsat[i] ? FNMAX[W-1:0] : fq[i][W-1:0];
				fout[i] = ~cm + 1'b1;
			end else begin
				fsat[i] = fq[i] > FPMAX;
				cm = fsat[i] ? FPMAX[W-1:0] : fq[i][W-1:0];
				fout[i] = cm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deg_d) begin
			result.force_x <= '0;
			result.force_y <= '0;
			result.force_z <= '0;
			result.degenerate <= 1'b1;
			result.saturated <= 1'b0;
		end else begin
			result.force_x <= fout[0];
			result.force_y <= fout[1];
			result.force_z <= fout[2];
			result.degenerate <= 1'b0;
			result.saturated <= fflag_d[3] | (|fsat);
		end
	end

endmodule
